[rtl/core/key_matrix_tap_hold_scanner_macros.svh]
// ----------------------------------------------------------------------------
// Key matrix tap/hold scanner: assertion macros
// Both macros assume a clock named clk and an active-low reset named rst_n
// in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_TAP_HOLD_SCANNER_MACROS_SVH
`define KEY_MATRIX_TAP_HOLD_SCANNER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define KMTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KMTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KMTS_ASSERT_IMPL(lbl, ante, cons, msg)
`define KMTS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/core/kmts_pkg.sv]
// ----------------------------------------------------------------------------
// kmts_pkg
// Shared types and constants of the key matrix tap/hold scanner.
// ----------------------------------------------------------------------------
package kmts_pkg;

  // default matrix size
  localparam int COLS_DEF = 8;
  localparam int ROWS_DEF = 4;

  // at most this many rows are scanned per column
  localparam int MAX_ROWS = 4;

  // field widths
  localparam int CNT_W     = 4;
  localparam int SCOL_W    = 3;
  localparam int ECOL_W    = 5;
  localparam int EROW_W    = 2;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [CNT_W-1:0] COL_OFFSET_RST   = 4'd0;
  localparam logic [CNT_W-1:0] HOLD_COUNT_RST   = 4'd4;
  localparam logic [CNT_W-1:0] REPEAT_AFTER_RST = 4'd7;

  // register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_COL_OFFSET   = 2'd0,
    REG_HOLD_COUNT   = 2'd1,
    REG_REPEAT_AFTER = 2'd2,
    REG_NONE         = 2'd3
  } reg_idx_t;

  typedef logic [CNT_W-1:0] cnt_t;

  // configuration seen by the front
  typedef struct packed {
    cnt_t col_offset;
    cnt_t hold_count;
    cnt_t repeat_after;
  } cfg_t;

  // one column's worth of events: output column and the rows that fire
  typedef struct packed {
    logic [ECOL_W-1:0]   col;
    logic [MAX_ROWS-1:0] mask;
  } evt_grp_t;

endpackage

[rtl/core/kmts_in_if.sv]
// ----------------------------------------------------------------------------
// kmts_in_if
// Column reading channel: valid/ready with column index and row sense bits.
// ----------------------------------------------------------------------------
interface kmts_in_if;
  logic                          valid;
  logic                          ready;
  logic [kmts_pkg::SCOL_W-1:0]   scan_column;
  logic [kmts_pkg::MAX_ROWS-1:0] row_bits;

  modport source (output valid, output scan_column, output row_bits, input ready);
  modport sink   (input valid, input scan_column, input row_bits, output ready);
endinterface

[rtl/core/kmts_out_if.sv]
// ----------------------------------------------------------------------------
// kmts_out_if
// Key event channel: valid/ready with event column, row and last flag.
// ----------------------------------------------------------------------------
interface kmts_out_if;
  logic                        valid;
  logic                        ready;
  logic [kmts_pkg::ECOL_W-1:0] event_col;
  logic [kmts_pkg::EROW_W-1:0] event_row;
  logic                        last;

  modport source (output valid, output event_col, output event_row, output last,
                  input ready);
  modport sink   (input valid, input event_col, input event_row, input last,
                  output ready);
endinterface

[rtl/core/kmts_ram.sv]
// ----------------------------------------------------------------------------
// kmts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

[rtl/core/kmts_queue.sv]
// ----------------------------------------------------------------------------
// kmts_queue
// Short FIFO of event groups between the front and the back.
// ----------------------------------------------------------------------------
module kmts_queue #(
  parameter int DEPTH = kmts_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  kmts_pkg::evt_grp_t push_grp,
  output logic               push_ready,
  input  logic               pop,
  output logic               head_vld,
  output kmts_pkg::evt_grp_t head_grp
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL   = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);

  kmts_pkg::evt_grp_t slot_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r,  cnt_nxt;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != FULL);
  assign head_vld   = (cnt_r != '0);
  assign head_grp   = slot_r[rptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_vld;

  // pointer and fill count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LAST_P) ? '0 : wptr_r + PW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST_P) ? '0 : rptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_grp;
    end
  end

endmodule

[rtl/core/kmts_front.sv]
// ----------------------------------------------------------------------------
// kmts_front
// Accepts column readings, reads the column's press counters from RAM,
// updates them and hands the set of firing rows to the queue.
// ----------------------------------------------------------------------------
module kmts_front #(
  parameter int COLS = kmts_pkg::COLS_DEF,
  parameter int ROWS = kmts_pkg::ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  kmts_in_if.sink            in_bus,
  input  kmts_pkg::cfg_t     cfg,
  output logic               grp_push,
  output kmts_pkg::evt_grp_t grp,
  input  logic               grp_ready
);

  // rows actually scanned and counter row layout
  localparam int RS   = (ROWS < kmts_pkg::MAX_ROWS) ? ROWS : kmts_pkg::MAX_ROWS;
  localparam int CNTW = kmts_pkg::CNT_W;
  localparam int RW   = RS * CNTW;
  localparam int CW   = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int IW   = kmts_pkg::SCOL_W + 1;
  localparam logic [IW:0] COLS_V = (IW + 1)'(COLS);

  logic [COLS-1:0]                 vld_r;
  logic                            s1_vld_r;
  logic [kmts_pkg::SCOL_W-1:0]     s1_col_r;
  logic [kmts_pkg::MAX_ROWS-1:0]   s1_bits_r;
  logic                            s1_init_r;
  logic                            fwd_hit_r;
  logic [RW-1:0]                   fwd_data_r;

  logic [IW-1:0]                   in_col_x, s1_col_x;
  logic [CW-1:0]                   in_idx, s1_idx;
  logic                            in_range, accept, s1_go;
  logic [RW-1:0]                   ram_rdata, cur_row, new_row;
  logic [kmts_pkg::MAX_ROWS-1:0]   emit;
  kmts_pkg::cnt_t                  cap;

  assign in_col_x = {1'b0, in_bus.scan_column};
  assign s1_col_x = {1'b0, s1_col_r};
  assign in_idx   = in_col_x[CW-1:0];
  assign s1_idx   = s1_col_x[CW-1:0];
  assign in_range = ({1'b0, in_col_x} < COLS_V);

  // stage 1 moves on when nothing fires or the queue has room
  assign s1_go        = s1_vld_r && ((emit == '0) || grp_ready);
  assign in_bus.ready = !s1_vld_r || s1_go;
  assign accept       = in_bus.valid && in_bus.ready;

  // counter row storage, one entry per column
  kmts_ram #(
    .WIDTH (RW),
    .DEPTH (COLS)
  ) u_cnt_ram (
    .clk     (clk),
    .we      (s1_go),
    .waddr   (s1_idx),
    .wdata   (new_row),
    .re      (accept),
    .raddr   (in_idx),
    .rdata_r (ram_rdata)
  );

  // current counters: forwarded write, RAM data, or reset value
  always_comb begin
    if (fwd_hit_r) begin
      cur_row = fwd_data_r;
    end else if (s1_init_r) begin
      cur_row = ram_rdata;
    end else begin
      cur_row = '0;
    end
  end

  // saturation point: repeat_after + 1, held at 15
  assign cap = (cfg.repeat_after == '1) ? '1 : cfg.repeat_after + CNTW'(1);

  // per-key count update and event decision
  always_comb begin
    kmts_pkg::cnt_t c;
    emit    = '0;
    new_row = cur_row;
    for (int r = 0; r < RS; r++) begin
      c = cur_row[r*CNTW +: CNTW];
      if (s1_bits_r[r]) begin
        if (c < cap) begin
          c = c + CNTW'(1);
        end
        emit[r] = (c == cfg.hold_count) || (c > cfg.repeat_after);
      end else if (c != '0) begin
        emit[r] = (c < cfg.hold_count);
        c = '0;
      end
      new_row[r*CNTW +: CNTW] = c;
    end
  end

  assign grp_push = s1_go && (emit != '0);
  assign grp.col  = kmts_pkg::ECOL_W'(s1_col_r) + kmts_pkg::ECOL_W'(cfg.col_offset);
  assign grp.mask = emit;

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      vld_r    <= '0;
    end else begin
      if (accept) begin
        s1_vld_r <= in_range;
      end else if (s1_go) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_go) begin
        vld_r[s1_idx] <= 1'b1;
      end
    end
  end

  // stage 1 payload and write forwarding
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r   <= in_bus.scan_column;
      s1_bits_r  <= in_bus.row_bits;
      s1_init_r  <= vld_r[in_idx];
      fwd_hit_r  <= s1_go && (s1_col_r == in_bus.scan_column);
      fwd_data_r <= new_row;
    end
  end

endmodule

[rtl/core/kmts_back.sv]
// ----------------------------------------------------------------------------
// kmts_back
// Takes event groups from the queue and sends one event per beat,
// lowest row first, flagging the last one of the group.
// ----------------------------------------------------------------------------
module kmts_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_vld,
  input  kmts_pkg::evt_grp_t head_grp,
  output logic               pop,
  kmts_out_if.source         out_bus
);

  logic                          bk_vld_r, bk_vld_nxt;
  kmts_pkg::evt_grp_t            bk_grp_r, bk_grp_nxt;
  logic [kmts_pkg::MAX_ROWS-1:0] rest;
  logic [kmts_pkg::EROW_W-1:0]   row_sel;
  logic                          is_last, beat;

  // lowest pending row
  always_comb begin
    row_sel = '0;
    for (int r = kmts_pkg::MAX_ROWS - 1; r >= 0; r--) begin
      if (bk_grp_r.mask[r]) begin
        row_sel = kmts_pkg::EROW_W'(r);
      end
    end
  end

  assign rest    = bk_grp_r.mask & (bk_grp_r.mask - kmts_pkg::MAX_ROWS'(1));
  assign is_last = (rest == '0);
  assign beat    = out_bus.valid && out_bus.ready;
  assign pop     = head_vld && (!bk_vld_r || (beat && is_last));

  assign out_bus.valid     = bk_vld_r;
  assign out_bus.event_col = bk_grp_r.col;
  assign out_bus.event_row = row_sel;
  assign out_bus.last      = is_last;

  // working group update
  always_comb begin
    bk_vld_nxt = bk_vld_r;
    bk_grp_nxt = bk_grp_r;
    if (pop) begin
      bk_vld_nxt = 1'b1;
      bk_grp_nxt = head_grp;
    end else if (beat) begin
      bk_vld_nxt      = !is_last;
      bk_grp_nxt.mask = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_vld_r <= 1'b0;
    end else begin
      bk_vld_r <= bk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bk_grp_r <= bk_grp_nxt;
  end

endmodule

[rtl/core/key_matrix_tap_hold_scanner.sv]
// ----------------------------------------------------------------------------
// key_matrix_tap_hold_scanner
// Column-reading key scanner with per-key press counters, hold/repeat
// events and short-press (tap) events on release.
//
//   channel   | dir | handshake         | payload
//   ----------+-----+-------------------+--------------------------------
//   in_bus    | in  | valid/ready       | scan_column[2:0], row_bits[3:0]
//   out_bus   | out | valid/ready       | event_col[4:0], event_row[1:0], last
//   cfg (APB) | in  | psel/penable      | paddr[3:0], pwdata/prdata[31:0]
//
// A reading is taken every cycle while the counter stage is free; it sees its
// counters in the next cycle from the counter RAM, which bounds the front at one
// reading per cycle. Events leave one per beat, at most 4 from one reading.
// The front stalls only when the event queue is full; the back stalls only on
// out_bus.ready. Reset is synchronous; counter RAM needs no clearing pass, a
// valid bit per column stands in for zero.
// ----------------------------------------------------------------------------
`include "key_matrix_tap_hold_scanner_macros.svh"

module key_matrix_tap_hold_scanner #(
  parameter int COLS = kmts_pkg::COLS_DEF,
  parameter int ROWS = kmts_pkg::ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  kmts_in_if.sink                           in_bus,
  kmts_out_if.source                        out_bus,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kmts_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [kmts_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [kmts_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);

  kmts_pkg::cfg_t     cfg_r;
  kmts_pkg::reg_idx_t reg_sel;
  logic               cfg_wr;
  logic               q_push, q_ready, q_pop, q_vld;
  kmts_pkg::evt_grp_t q_in_grp, q_head_grp;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = kmts_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.col_offset   <= kmts_pkg::COL_OFFSET_RST;
      cfg_r.hold_count   <= kmts_pkg::HOLD_COUNT_RST;
      cfg_r.repeat_after <= kmts_pkg::REPEAT_AFTER_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        kmts_pkg::REG_COL_OFFSET:   cfg_r.col_offset   <= pwdata[kmts_pkg::CNT_W-1:0];
        kmts_pkg::REG_HOLD_COUNT:   cfg_r.hold_count   <= pwdata[kmts_pkg::CNT_W-1:0];
        kmts_pkg::REG_REPEAT_AFTER: cfg_r.repeat_after <= pwdata[kmts_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      kmts_pkg::REG_COL_OFFSET:   prdata = kmts_pkg::CFG_DATA_W'(cfg_r.col_offset);
      kmts_pkg::REG_HOLD_COUNT:   prdata = kmts_pkg::CFG_DATA_W'(cfg_r.hold_count);
      kmts_pkg::REG_REPEAT_AFTER: prdata = kmts_pkg::CFG_DATA_W'(cfg_r.repeat_after);
      default:                    prdata = '0;
    endcase
  end

  // front: counters and event decision
  kmts_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .cfg       (cfg_r),
    .grp_push  (q_push),
    .grp       (q_in_grp),
    .grp_ready (q_ready)
  );

  // queue of pending event groups
  kmts_queue #(
    .DEPTH (kmts_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_grp   (q_in_grp),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_vld   (q_vld),
    .head_grp   (q_head_grp)
  );

  // back: event sequencer
  kmts_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_vld (q_vld),
    .head_grp (q_head_grp),
    .pop      (q_pop),
    .out_bus  (out_bus)
  );

  // checks
  `KMTS_ASSERT_IMPL(a_no_overflow, q_push, q_ready, "event queue overflow")
  `KMTS_ASSERT_IMPL(a_pop_has_data, q_pop, q_vld, "pop from empty event queue")
  `KMTS_ASSERT_NEXT(a_group_continues, out_bus.valid && out_bus.ready && !out_bus.last, out_bus.valid, "event group cut short")

endmodule
